// File: hw/rtl/lev_pkg.sv
package lev_pkg;

  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int OUT_LEN_W = 7;
  localparam int FRAC_W    = 16;
  localparam int NORM_W    = FRAC_W + 1;
  localparam int CNT_W     = $clog2(FRAC_W);

  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  localparam logic [NORM_W-1:0] NORM_ONE = 17'h10000;
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(FRAC_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_DIVIDE,
    ST_DONE
  } lev_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic active;
  } lev_cell_ctl_t;

endpackage

// File: hw/rtl/lev_cell.sv
module lev_cell #(
  parameter int LEN_W = 7,
  parameter int IDX   = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lev_pkg::lev_cell_ctl_t      ctl,
  input  logic [lev_pkg::CHAR_W-1:0]  load_char,
  input  logic                        in_valid,
  input  logic [lev_pkg::CHAR_W-1:0]  in_char,
  input  logic [LEN_W-1:0]            in_left,
  input  logic [LEN_W-1:0]            in_diag,
  output logic                        out_valid_r,
  output logic [lev_pkg::CHAR_W-1:0]  out_char_r,
  output logic [LEN_W-1:0]            out_left_r,
  output logic [LEN_W-1:0]            out_diag_r
);
  import lev_pkg::*;

  logic [CHAR_W-1:0] char_r;
  logic [LEN_W-1:0]  cost_r;
  logic [LEN_W-1:0]  cost_nxt;
  logic [LEN_W:0]    up_c;
  logic [LEN_W:0]    left_c;
  logic [LEN_W:0]    sub_c;
  logic [LEN_W:0]    best;
  logic [LEN_W-1:0]  left_nxt;
  logic [LEN_W-1:0]  diag_nxt;

  always_comb begin
    up_c   = {1'b0, cost_r} + (LEN_W+1)'(1);
    left_c = {1'b0, in_left} + (LEN_W+1)'(1);
    sub_c  = {1'b0, in_diag} + (LEN_W+1)'(char_r != in_char);
    best   = up_c;
    if (left_c < best) begin
      best = left_c;
    end
    if (sub_c < best) begin
      best = sub_c;
    end
  end

  always_comb begin
    cost_nxt = cost_r;
    left_nxt = in_left;
    diag_nxt = in_diag;
    if (ctl.active) begin
      left_nxt = best[LEN_W-1:0];
      diag_nxt = cost_r;
    end
    if (ctl.clear) begin
      cost_nxt = LEN_W'(IDX);
    end else if (in_valid && ctl.active) begin
      cost_nxt = best[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r      <= LEN_W'(IDX);
      out_valid_r <= 1'b0;
    end else begin
      cost_r      <= cost_nxt;
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      char_r <= load_char;
    end
    out_char_r <= in_char;
    out_left_r <= left_nxt;
    out_diag_r <= diag_nxt;
  end

endmodule

// File: hw/rtl/lev_div.sv
module lev_div #(
  parameter int LEN_W = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [LEN_W-1:0]            dividend,
  input  logic [LEN_W-1:0]            divisor,
  output logic                        done,
  output logic [lev_pkg::NORM_W-1:0]  quotient
);
  import lev_pkg::*;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W:0]    rem_r, rem_nxt;
  logic [LEN_W-1:0]  div_r, div_nxt;
  logic [NORM_W-1:0] q_r, q_nxt;
  logic [LEN_W:0]    rem_sh;
  logic [LEN_W:0]    rem_step;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r[LEN_W-1:0], 1'b0};
    ge       = rem_sh >= {1'b0, div_r};
    rem_step = ge ? rem_sh - {1'b0, div_r} : rem_sh;
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    if (start) begin
      div_nxt = divisor;
      cnt_nxt = CNT_LAST;
      rem_nxt = {1'b0, dividend};
      if (divisor == '0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else if (dividend >= divisor) begin
        q_nxt    = NORM_ONE;
        done_nxt = 1'b1;
      end else begin
        q_nxt   = '0;
        run_nxt = 1'b1;
      end
    end else if (run_r) begin
      rem_nxt = rem_step;
      q_nxt   = {q_r[NORM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: hw/rtl/levenshtein_edit_distance_unit.sv
// Levenshtein edit distance between two byte strings.
// A request is taken at a rising edge with start high and busy low. in_req_type
// selects: first-string byte, second-string byte, or finish of the pair.
// First-string bytes are written into a row of MAX_LEN cells, one byte per cell.
// Each second-string byte starts a row update that walks down the cell chain one
// cell per cycle, so byte requests of either kind are taken every cycle while busy is low.
// Bytes past MAX_LEN are dropped and set the overflow flag; first-string bytes
// that come after second-string bytes are dropped without it.
// A finish raises busy while the chain drains and the 16-step shift-subtract
// divider forms the normalized distance; out_valid then pulses for one cycle.
// The pair is cleared and busy drops in the cycle after that pulse.
// Drain length is set by the cell chain, the divide time by the divider.
// The receiver cannot stall: out_valid marks the result for one cycle only.
// Reset is synchronous, active low; it clears the pair and leaves the block idle.
module levenshtein_edit_distance_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lev_pkg::REQ_W-1:0]      in_req_type,
  input  logic [lev_pkg::CHAR_W-1:0]     in_char_value,
  output logic                           out_valid,
  output logic [lev_pkg::OUT_LEN_W-1:0]  out_edit_distance,
  output logic [lev_pkg::OUT_LEN_W-1:0]  out_longer_length,
  output logic [lev_pkg::NORM_W-1:0]     out_normalized_distance,
  output logic                           out_overflow
);
  import lev_pkg::*;

  localparam int                LEN_W     = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W-1:0]  MAX_LEN_V = LEN_W'(MAX_LEN);

  lev_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  first_len_r, first_len_nxt;
  logic [LEN_W-1:0]  sec_len_r, sec_len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  drain_cnt_r, drain_cnt_nxt;
  logic              head_valid_r, head_valid_nxt;
  logic [CHAR_W-1:0] head_char_r;
  logic [LEN_W-1:0]  head_left_r, head_left_nxt;
  logic [LEN_W-1:0]  head_diag_r, head_diag_nxt;
  logic [LEN_W-1:0]  tail_dist_r;
  logic [LEN_W-1:0]  dist_r;
  logic [LEN_W-1:0]  longer_r;

  logic              accept;
  logic              load_first;
  logic              clear_pair;
  logic              div_start;
  logic              div_done;
  logic [NORM_W-1:0] div_q;
  logic [LEN_W-1:0]  dist_sel;
  logic [LEN_W-1:0]  longer_sel;

  logic [LEN_W+OUT_LEN_W-1:0] dist_wide;
  logic [LEN_W+OUT_LEN_W-1:0] longer_wide;

  logic              bus_valid [0:MAX_LEN];
  logic [CHAR_W-1:0] bus_char  [0:MAX_LEN];
  logic [LEN_W-1:0]  bus_left  [0:MAX_LEN];
  logic [LEN_W-1:0]  bus_diag  [0:MAX_LEN];

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_FINISH) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt_r == '0) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    busy       = 1'b1;
    div_start  = 1'b0;
    out_valid  = 1'b0;
    clear_pair = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_DRAIN: begin
        div_start = (drain_cnt_r == '0);
      end
      ST_DIVIDE: begin
        busy = 1'b1;
      end
      ST_DONE: begin
        out_valid  = 1'b1;
        clear_pair = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // request handling
  always_comb begin
    first_len_nxt  = first_len_r;
    sec_len_nxt    = sec_len_r;
    ovf_nxt        = ovf_r;
    load_first     = 1'b0;
    head_valid_nxt = 1'b0;
    head_left_nxt  = sec_len_r + LEN_W'(1);
    head_diag_nxt  = sec_len_r;
    drain_cnt_nxt  = drain_cnt_r;
    if (state_r == ST_DRAIN && drain_cnt_r != '0) begin
      drain_cnt_nxt = drain_cnt_r - LEN_W'(1);
    end
    if (clear_pair) begin
      first_len_nxt = '0;
      sec_len_nxt   = '0;
      ovf_nxt       = 1'b0;
    end else if (accept) begin
      unique case (in_req_type)
        REQ_FIRST: begin
          if (sec_len_r == '0) begin
            if (first_len_r >= MAX_LEN_V) begin
              ovf_nxt = 1'b1;
            end else begin
              load_first    = 1'b1;
              first_len_nxt = first_len_r + LEN_W'(1);
            end
          end
        end
        REQ_SECOND: begin
          if (sec_len_r >= MAX_LEN_V) begin
            ovf_nxt = 1'b1;
          end else begin
            sec_len_nxt    = sec_len_r + LEN_W'(1);
            head_valid_nxt = 1'b1;
          end
        end
        REQ_FINISH: begin
          drain_cnt_nxt = MAX_LEN_V;
        end
        default: begin
          ovf_nxt = ovf_r;
        end
      endcase
    end
  end

  always_comb begin
    dist_sel   = (sec_len_r == '0) ? first_len_r : tail_dist_r;
    longer_sel = (first_len_r > sec_len_r) ? first_len_r : sec_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_len_r  <= '0;
      sec_len_r    <= '0;
      ovf_r        <= 1'b0;
      drain_cnt_r  <= '0;
      head_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_len_r  <= first_len_nxt;
      sec_len_r    <= sec_len_nxt;
      ovf_r        <= ovf_nxt;
      drain_cnt_r  <= drain_cnt_nxt;
      head_valid_r <= head_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_char_r <= in_char_value;
    head_left_r <= head_left_nxt;
    head_diag_r <= head_diag_nxt;
    if (bus_valid[MAX_LEN]) begin
      tail_dist_r <= bus_left[MAX_LEN];
    end
    if (div_start) begin
      dist_r   <= dist_sel;
      longer_r <= longer_sel;
    end
  end

  assign bus_valid[0] = head_valid_r;
  assign bus_char[0]  = head_char_r;
  assign bus_left[0]  = head_left_r;
  assign bus_diag[0]  = head_diag_r;

  for (genvar gi = 1; gi <= MAX_LEN; gi++) begin : g_cell
    lev_cell_ctl_t cell_ctl;

    assign cell_ctl.load   = load_first && (first_len_r == LEN_W'(gi - 1));
    assign cell_ctl.clear  = clear_pair;
    assign cell_ctl.active = (LEN_W'(gi) <= first_len_r);

    lev_cell #(
      .LEN_W (LEN_W),
      .IDX   (gi)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl),
      .load_char   (in_char_value),
      .in_valid    (bus_valid[gi-1]),
      .in_char     (bus_char[gi-1]),
      .in_left     (bus_left[gi-1]),
      .in_diag     (bus_diag[gi-1]),
      .out_valid_r (bus_valid[gi]),
      .out_char_r  (bus_char[gi]),
      .out_left_r  (bus_left[gi]),
      .out_diag_r  (bus_diag[gi])
    );
  end

  lev_div #(
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dist_sel),
    .divisor  (longer_sel),
    .done     (div_done),
    .quotient (div_q)
  );

  assign dist_wide   = {{OUT_LEN_W{1'b0}}, dist_r};
  assign longer_wide = {{OUT_LEN_W{1'b0}}, longer_r};

  assign out_edit_distance       = dist_wide[OUT_LEN_W-1:0];
  assign out_longer_length       = longer_wide[OUT_LEN_W-1:0];
  assign out_normalized_distance = div_q;
  assign out_overflow            = ovf_r;

  a_valid_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_clear_after_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (first_len_r == '0 && sec_len_r == '0 && !ovf_r))
    else $error("pair not cleared after result");

  a_row_has_length : assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r |-> (sec_len_r != '0))
    else $error("row update without second-string length");

  a_sec_saturates : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_SECOND && sec_len_r == MAX_LEN_V) |=>
      ($stable(sec_len_r) && ovf_r && !head_valid_r))
    else $error("second string grew past its limit");

  a_norm_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_normalized_distance <= NORM_ONE))
    else $error("normalized distance above one");

endmodule
